FILE: hdl/npe_pkg.sv
// constants and types shared by the normal distribution evaluator
package npe_pkg;

  typedef logic [30:0] npe_value_t;

  localparam npe_value_t VALUE_MAX = 31'h7FFF_FFFF;

  // |z| carries 26 fractional bits and saturates at the top of its range
  localparam int         Z_FRAC      = 26;
  localparam logic [30:0] Z_SAT       = 31'h7FFF_FFFF;
  localparam logic [30:0] Z_LIMIT_PDF = 31'h4000_0000;
  localparam logic [30:0] Z_LIMIT_CDF = 31'h1800_0000;

  localparam logic [31:0] ONE31  = 32'h8000_0000;
  localparam logic [63:0] HALF31 = 64'h4000_0000;

  localparam logic [28:0] K_SCALE      = 29'd497447192;
  localparam logic [29:0] INV_SQRT_2PI = 30'd856722024;

  localparam int HORNER_TERMS = 12;
  localparam int SQUARINGS    = 7;
  localparam int POLY_TERMS   = 5;

  // floor(2^32 / n) for n = 1 .. 12, entry n-1
  localparam logic [32:0] HRN_RECIP [HORNER_TERMS] = '{
    33'h1_0000_0000, 33'h0_8000_0000, 33'h0_5555_5555, 33'h0_4000_0000,
    33'h0_3333_3333, 33'h0_2AAA_AAAA, 33'h0_2492_4924, 33'h0_2000_0000,
    33'h0_1C71_C71C, 33'h0_1999_9999, 33'h0_1745_D174, 33'h0_1555_5555
  };

  // tail polynomial coefficients, 31 fractional bits, lowest order first
  localparam logic signed [33:0] POLY_COEF [POLY_TERMS] = '{
    34'sd685866613, -34'sd765714890, 34'sd3825694740,
    -34'sd3911117432, 34'sd2856742584
  };

endpackage

FILE: hdl/npe_div.sv
// pipelined restoring divider, one quotient bit per register stage
module npe_div #(
  parameter int QW = 31,
  parameter int DW = 31
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];

  logic [DW-1:0] rem_in  [QW];
  logic [DW-1:0] den_in  [QW];
  logic [QW-1:0] low_in  [QW];
  logic [QW-1:0] quo_in  [QW];
  logic [DW:0]   trial   [QW];
  logic [DW:0]   diff    [QW];
  logic          ge      [QW];
  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] low_nxt [QW];
  logic [QW-1:0] quo_nxt [QW];

  always_comb begin
    rem_in[0] = rem_i;
    den_in[0] = den_i;
    low_in[0] = low_i;
    quo_in[0] = '0;
    for (int s = 1; s < QW; s++) begin
      rem_in[s] = rem_r[s-1];
      den_in[s] = den_r[s-1];
      low_in[s] = low_r[s-1];
      quo_in[s] = quo_r[s-1];
    end
    for (int s = 0; s < QW; s++) begin
      trial[s]   = {rem_in[s], low_in[s][QW-1]};
      diff[s]    = trial[s] - {1'b0, den_in[s]};
      ge[s]      = trial[s] >= {1'b0, den_in[s]};
      rem_nxt[s] = ge[s] ? diff[s][DW-1:0] : trial[s][DW-1:0];
      low_nxt[s] = low_in[s] << 1;
      quo_nxt[s] = {quo_in[s][QW-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int s = 0; s < QW; s++) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= den_in[s];
        low_r[s] <= low_nxt[s];
        quo_r[s] <= quo_nxt[s];
      end
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule

FILE: hdl/npe_dly.sv
// delay line that moves with the pipeline enable
module npe_dly #(
  parameter int W = 1,
  parameter int L = 1
) (
  input  logic         clk,
  input  logic         ce,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_r [L];

  always_ff @(posedge clk) begin
    if (ce) begin
      sr_r[0] <= d_i;
      for (int i = 1; i < L; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q_o = sr_r[L-1];

endmodule

FILE: hdl/normal_pdf_cdf_eval.sv
// Normal density / cumulative probability evaluator. Takes one word per clock while the
// input is ready and returns one result word per input word. The latency is set by
// the three restoring dividers (|z|, the polynomial argument k and the density scaling by
// st_dev, each one quotient bit per stage) and by the 12-term exp series, which spends
// three stages on each term. A two-word output buffer keeps the input ready while one
// result waits; the whole pipeline holds only when both words of the buffer are full.
module normal_pdf_cdf_eval
  import npe_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // x[31:0], mean[63:32], st_dev[94:64], zero pad
  input  logic [0:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value[30:0], zero pad
  output logic [0:0]  out_tuser   // saturated
);

  localparam int LAT = 109;
  localparam int PDF_SHIFT = 2 * FRAC_BITS - 31;
  localparam int OUT_SHIFT = 31 - FRAC_BITS;
  localparam logic [32:0] OUT_RND = 33'd1 << (30 - FRAC_BITS);
  localparam npe_value_t CDF_ONE = 31'd1 << FRAC_BITS;

  logic ce;
  logic [LAT-1:0] v_r;
  logic out_valid_r, skid_valid_r;
  npe_value_t out_value_r, skid_value_r;
  logic out_sat_r, skid_sat_r;

  assign ce = !skid_valid_r;
  assign in_tready = ce;

  // input stage: difference magnitude and sign
  logic [32:0] diff_nxt, mag_nxt;
  logic [30:0] sd_nxt;
  logic        func1_r, neg1_r;
  logic [32:0] mag1_r;
  logic [30:0] sd1_r;

  always_comb begin
    diff_nxt = {in_tdata[31], in_tdata[31:0]} - {in_tdata[63], in_tdata[63:32]};
    mag_nxt  = diff_nxt[32] ? (~diff_nxt + 33'd1) : diff_nxt;
    sd_nxt   = (in_tdata[94:64] == 31'd0) ? 31'd1 : in_tdata[94:64];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      func1_r <= in_tuser[0];
      neg1_r  <= diff_nxt[32];
      mag1_r  <= mag_nxt;
      sd1_r   <= sd_nxt;
    end
  end

  // |z| = (|d| << 26) / st_dev
  logic [30:0] zq;
  logic        zovf_nxt, zovf32;

  assign zovf_nxt = {3'd0, mag1_r} >= {sd1_r, 5'd0};

  npe_div #(.QW(31), .DW(31)) u_zdiv (
    .clk   (clk),
    .ce    (ce),
    .rem_i ({3'd0, mag1_r[32:5]}),
    .low_i ({mag1_r[4:0], 26'd0}),
    .den_i (sd1_r),
    .quo_o (zq)
  );

  npe_dly #(.W(1), .L(31)) u_zovf_dly (.clk(clk), .ce(ce), .d_i(zovf_nxt), .q_o(zovf32));

  logic        neg79, func109;
  logic [30:0] sd78;
  npe_dly #(.W(1), .L(78)) u_neg_dly (.clk(clk), .ce(ce), .d_i(neg1_r), .q_o(neg79));
  npe_dly #(.W(1), .L(108)) u_func_dly (.clk(clk), .ce(ce), .d_i(func1_r), .q_o(func109));
  npe_dly #(.W(31), .L(77)) u_sd_dly (.clk(clk), .ce(ce), .d_i(sd1_r), .q_o(sd78));

  logic [30:0] z_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      z_r <= zovf32 ? Z_SAT : zq;
    end
  end

  // exp argument and polynomial denominator
  logic [59:0] zsq;
  logic [30:0] zc;
  logic [57:0] kz;
  logic [30:0] f_r;
  logic        zlim34_r, far34_r;
  logic [32:0] den_r;

  always_comb begin
    zsq = {30'd0, z_r[29:0]} * {30'd0, z_r[29:0]};
    zc  = (z_r > Z_LIMIT_CDF) ? Z_LIMIT_CDF : z_r;
    kz  = {29'd0, K_SCALE} * {29'd0, zc[28:0]};
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f_r      <= zsq[59:29];
      zlim34_r <= z_r >= Z_LIMIT_PDF;
      far34_r  <= z_r > Z_LIMIT_CDF;
      den_r    <= {1'b0, ONE31} + {1'b0, kz[57:26]};
    end
  end

  // exp(-f) series, three stages per term: product, reciprocal product, correction
  logic [30:0] hf_in    [HORNER_TERMS];
  logic [31:0] hg_in    [HORNER_TERMS];
  logic [62:0] hm_nxt   [HORNER_TERMS];
  logic [31:0] hp       [HORNER_TERMS];
  logic [64:0] ht_nxt   [HORNER_TERMS];
  logic [32:0] hq0      [HORNER_TERMS];
  logic [35:0] hrem     [HORNER_TERMS];
  logic [32:0] hq       [HORNER_TERMS];
  logic [31:0] hg_nxt   [HORNER_TERMS];
  logic [62:0] hm_r     [HORNER_TERMS];
  logic [64:0] ht_r     [HORNER_TERMS];
  logic [31:0] hpb_r    [HORNER_TERMS];
  logic [31:0] hg_r     [HORNER_TERMS];
  logic [30:0] hfa_r    [HORNER_TERMS];
  logic [30:0] hfb_r    [HORNER_TERMS];
  logic [30:0] hfc_r    [HORNER_TERMS];

  always_comb begin
    hf_in[0] = f_r;
    hg_in[0] = ONE31;
    for (int j = 1; j < HORNER_TERMS; j++) begin
      hf_in[j] = hfc_r[j-1];
      hg_in[j] = hg_r[j-1];
    end
    for (int j = 0; j < HORNER_TERMS; j++) begin
      hm_nxt[j] = 63'(hf_in[j]) * 63'(hg_in[j]);
      hp[j]     = hm_r[j][62:31];
      ht_nxt[j] = 65'(hp[j]) * 65'(HRN_RECIP[HORNER_TERMS-1-j]);
      hq0[j]    = ht_r[j][64:32];
      // reciprocal estimate is at most one low
      hrem[j]   = 36'(hpb_r[j]) - 36'(hq0[j]) * 36'(HORNER_TERMS - j);
      hq[j]     = hq0[j] + 33'(hrem[j] >= 36'(HORNER_TERMS - j));
      hg_nxt[j] = ONE31 - hq[j][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int j = 0; j < HORNER_TERMS; j++) begin
        hm_r[j]  <= hm_nxt[j];
        hfa_r[j] <= hf_in[j];
        ht_r[j]  <= ht_nxt[j];
        hpb_r[j] <= hp[j];
        hfb_r[j] <= hfa_r[j];
        hg_r[j]  <= hg_nxt[j];
        hfc_r[j] <= hfb_r[j];
      end
    end
  end

  // raise to the 128th power by repeated squaring
  logic [31:0] sq_in  [SQUARINGS];
  logic [63:0] sq_nxt [SQUARINGS];
  logic [31:0] sq_r   [SQUARINGS];

  always_comb begin
    sq_in[0] = hg_r[HORNER_TERMS-1];
    for (int i = 1; i < SQUARINGS; i++) begin
      sq_in[i] = sq_r[i-1];
    end
    for (int i = 0; i < SQUARINGS; i++) begin
      sq_nxt[i] = (64'(sq_in[i]) * 64'(sq_in[i]) + HALF31) >> 31;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < SQUARINGS; i++) begin
        sq_r[i] <= sq_nxt[i][31:0];
      end
    end
  end

  logic        zlim77;
  logic [63:0] phi_nxt;
  logic [30:0] phi_r;

  npe_dly #(.W(1), .L(43)) u_zlim_dly (.clk(clk), .ce(ce), .d_i(zlim34_r), .q_o(zlim77));

  assign phi_nxt = (64'(sq_r[SQUARINGS-1]) * 64'(INV_SQRT_2PI) + HALF31) >> 31;

  always_ff @(posedge clk) begin
    if (ce) begin
      phi_r <= zlim77 ? 31'd0 : phi_nxt[30:0];
    end
  end

  // k = 2^62 / den, rounded
  logic [31:0] kq;

  npe_div #(.QW(32), .DW(33)) u_kdiv (
    .clk   (clk),
    .ce    (ce),
    .rem_i (33'h0_4000_0000),
    .low_i (den_r[32:1]),
    .den_i (den_r),
    .quo_o (kq)
  );

  // tail polynomial, a product stage and a sum stage per coefficient
  logic signed [33:0] ps_in    [POLY_TERMS];
  logic        [31:0] pk       [POLY_TERMS];
  logic signed [33:0] pneg_val [POLY_TERMS];
  logic        [64:0] pprod_nxt[POLY_TERMS];
  logic        [64:0] prnd     [POLY_TERMS];
  logic signed [33:0] pr       [POLY_TERMS];
  logic        [64:0] pprod_r  [POLY_TERMS];
  logic               pneg_r   [POLY_TERMS];
  logic signed [33:0] ps_r     [POLY_TERMS-1];
  logic        [31:0] kd_r     [2*POLY_TERMS-2];
  logic        [32:0] pq_r, q77_r, q78_r;

  always_comb begin
    ps_in[0] = POLY_COEF[POLY_TERMS-1];
    pk[0]    = kq;
    for (int j = 1; j < POLY_TERMS; j++) begin
      ps_in[j] = ps_r[j-1];
      pk[j]    = kd_r[2*j-1];
    end
    for (int j = 0; j < POLY_TERMS; j++) begin
      pneg_val[j]  = ps_in[j][33] ? -ps_in[j] : ps_in[j];
      pprod_nxt[j] = {32'd0, pneg_val[j][32:0]} * {33'd0, pk[j]};
      prnd[j]      = (pprod_r[j] + 65'(HALF31)) >> 31;
      pr[j]        = signed'(prnd[j][33:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      kd_r[0] <= kq;
      for (int i = 1; i < 2 * POLY_TERMS - 2; i++) begin
        kd_r[i] <= kd_r[i-1];
      end
      for (int j = 0; j < POLY_TERMS; j++) begin
        pprod_r[j] <= pprod_nxt[j];
        pneg_r[j]  <= ps_in[j][33];
      end
      for (int j = 0; j < POLY_TERMS - 1; j++) begin
        ps_r[j] <= POLY_COEF[POLY_TERMS-2-j] + (pneg_r[j] ? -pr[j] : pr[j]);
      end
      // a negative sum clamps to zero
      pq_r  <= pneg_r[POLY_TERMS-1] ? 33'd0 : pr[POLY_TERMS-1][32:0];
      q77_r <= pq_r;
      q78_r <= q77_r;
    end
  end

  // cumulative probability
  logic        far79;
  logic [63:0] tprod_r;
  logic [63:0] trnd;
  logic [31:0] tail, c31;
  logic [32:0] csum;
  npe_value_t  cdf_nxt, cdf80_r, cdf109;

  npe_dly #(.W(1), .L(45)) u_far_dly (.clk(clk), .ce(ce), .d_i(far34_r), .q_o(far79));

  always_comb begin
    trnd = (tprod_r + HALF31) >> 31;
    tail = (trnd > 64'(ONE31)) ? ONE31 : trnd[31:0];
    c31  = neg79 ? tail : ONE31 - tail;
    csum = ({1'b0, c31} + OUT_RND) >> OUT_SHIFT;
    if (far79) begin
      cdf_nxt = neg79 ? 31'd0 : CDF_ONE;
    end else begin
      cdf_nxt = csum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      tprod_r <= 64'(phi_r) * 64'(q78_r);
      cdf80_r <= cdf_nxt;
    end
  end

  npe_dly #(.W(31), .L(29)) u_cdf_dly (.clk(clk), .ce(ce), .d_i(cdf80_r), .q_o(cdf109));

  // density = (phi << (2F-31) + sd/2) / sd
  logic [63:0] pn64;
  logic        povf_nxt, povf109;
  logic [30:0] dq;

  always_comb begin
    pn64     = (64'(phi_r) << PDF_SHIFT) + 64'(sd78 >> 1);
    povf_nxt = pn64[63:31] >= 33'(sd78);
  end

  npe_div #(.QW(31), .DW(31)) u_ddiv (
    .clk   (clk),
    .ce    (ce),
    .rem_i (pn64[61:31]),
    .low_i (pn64[30:0]),
    .den_i (sd78),
    .quo_o (dq)
  );

  npe_dly #(.W(1), .L(31)) u_povf_dly (.clk(clk), .ce(ce), .d_i(povf_nxt), .q_o(povf109));

  // result select and two-word output buffer
  npe_value_t res_value;
  logic       res_sat;

  always_comb begin
    if (func109) begin
      res_value = cdf109;
      res_sat   = 1'b0;
    end else begin
      res_value = povf109 ? VALUE_MAX : dq;
      res_sat   = povf109;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (ce) begin
        v_r <= {v_r[LAT-2:0], in_tvalid};
      end
      if (skid_valid_r) begin
        if (out_tready) begin
          skid_valid_r <= 1'b0;
        end
      end else if (!out_valid_r || out_tready) begin
        out_valid_r <= v_r[LAT-1];
      end else if (v_r[LAT-1]) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_value_r <= skid_value_r;
        out_sat_r   <= skid_sat_r;
      end
    end else if (!out_valid_r || out_tready) begin
      out_value_r <= res_value;
      out_sat_r   <= res_sat;
    end else begin
      skid_value_r <= res_value;
      skid_sat_r   <= res_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_value_r};
  assign out_tuser  = out_sat_r;

endmodule

FILE: hdl/npe_chk.sv
// port checker for the normal distribution evaluator, bound to the top level
module npe_chk
  import npe_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [95:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // saturation flag only ever comes with the clamped maximum
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[30:0] == VALUE_MAX)
    else $error("saturated result not at maximum");

  // input backs off only when a result is pending on the output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // first edge out of reset sees the buffer already cleared
  a_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("output buffer not cleared by reset");

endmodule

bind normal_pdf_cdf_eval npe_chk u_npe_chk (.*);

FILE: verif/tb.sv
// self-checking testbench for the normal density / cumulative probability evaluator
`timescale 1ns / 100ps

module tb;
  import npe_pkg::*;

  localparam int  FRAC = 24;
  localparam bit  FUNC_PDF = 1'b0;
  localparam bit  FUNC_CDF = 1'b1;
  localparam int  SETTLE_CYCLES = 150;
  localparam int  HOLD_CYCLES = 400;
  localparam longint unsigned Q31_ONE = 64'h8000_0000;
  localparam longint unsigned Q31_HALF = 64'h4000_0000;
  localparam longint unsigned ABS_Z_PDF_MAX = 64'd16 << 26;
  localparam longint unsigned ABS_Z_CDF_MAX = 64'd6 << 26;
  localparam longint unsigned GAUSS_NORM = 64'd856722024;
  localparam longint unsigned TAIL_SLOPE = 64'd497447192;
  localparam longint TAIL_COEF [5] = '{
    64'sd685866613, -64'sd765714890, 64'sd3825694740, -64'sd3911117432, 64'sd2856742584
  };

  typedef struct packed {
    logic [30:0] value;
    logic        sat;
  } prob_word_t;

  typedef struct {
    bit          func;
    logic [31:0] x;
    logic [31:0] mean;
    logic [30:0] sd;
    bit          typed;
    prob_word_t  want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // x, mean, st_dev, zero pad
  logic [0:0]  in_tuser = '0;   // func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // value, zero pad
  logic [0:0]  out_tuser;       // saturated

  prob_word_t  pending_probs [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  normal_pdf_cdf_eval #(.FRAC_BITS(FRAC)) dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned gauss_density(longint unsigned z);
    longint unsigned f, g;
    if (z >= ABS_Z_PDF_MAX) return 0;
    f = (z * z) >> 29;
    g = Q31_ONE;
    for (int n = 12; n >= 1; n--) g = Q31_ONE - ((f * g) >> 31) / longint'(n);
    for (int n = 0; n < 7; n++) g = (g * g + Q31_HALF) >> 31;
    return (g * GAUSS_NORM + Q31_HALF) >> 31;
  endfunction

  function automatic longint scale_by_k(longint s, longint unsigned k);
    longint unsigned m, p;
    m = (s < 0) ? longint'(-s) : s;
    p = (m * k + Q31_HALF) >> 31;
    return (s < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic prob_word_t normal_eval(bit func, logic [31:0] x, logic [31:0] mean,
                                             logic [30:0] sd_in);
    longint          d, s;
    longint unsigned mag, sd, z, val, den, k, q, tail;
    bit              neg;
    prob_word_t      r;
    d = longint'($signed(x)) - longint'($signed(mean));
    neg = d < 0;
    mag = neg ? -d : d;
    sd = (sd_in == 0) ? 1 : sd_in;
    z = (mag << 26) / sd;
    r.sat = 1'b0;
    if (func == FUNC_PDF) begin
      val = ((gauss_density(z) << (2 * FRAC - 31)) + sd / 2) / sd;
      if (val > VALUE_MAX) begin
        val = VALUE_MAX;
        r.sat = 1'b1;
      end
    end else if (z > ABS_Z_CDF_MAX) begin
      val = neg ? 0 : (64'd1 << FRAC);
    end else begin
      den = Q31_ONE + ((TAIL_SLOPE * z) >> 26);
      k = ((64'd1 << 62) + den / 2) / den;
      s = TAIL_COEF[4];
      for (int i = 3; i >= 0; i--) s = TAIL_COEF[i] + scale_by_k(s, k);
      s = scale_by_k(s, k);
      q = (s < 0) ? 0 : s;
      tail = (gauss_density(z) * q + Q31_HALF) >> 31;
      if (tail > Q31_ONE) tail = Q31_ONE;
      val = ((neg ? tail : Q31_ONE - tail) + (64'd1 << (30 - FRAC))) >> (31 - FRAC);
    end
    r.value = val[30:0];
    return r;
  endfunction

  task automatic offer_word(bit func, logic [31:0] x, logic [31:0] mean, logic [30:0] sd,
                            bit typed, prob_word_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, sd, mean, x};
    in_tuser  <= func;
    do @(posedge clk); while (!in_tready);
    pending_probs.push_back(typed ? want : normal_eval(func, x, mean, sd));
  endtask

  task automatic offer_random_word();
    logic [31:0] x, mean;
    logic [30:0] sd;
    longint      off;
    prob_word_t  none;
    none = '0;
    if ($urandom_range(4) == 0) begin
      x = $urandom;
      mean = $urandom;
      sd = 31'($urandom);
    end else begin
      // keep z within about +/-9 so the polynomial and density paths get exercised
      mean = 32'(longint'($urandom_range(0, 32'h2000_0000)) - 64'h1000_0000);
      sd = 31'($urandom_range(1, 32'h0800_0000) >> $urandom_range(0, 22));
      if (sd == 0) sd = 1;
      off = (longint'(sd) * (longint'($urandom_range(0, 4608)) - 2304)) / 256;
      x = 32'(longint'($signed(mean)) + off);
    end
    offer_word(1'($urandom_range(1)), x, mean, sd, 1'b0, none);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      hold_req  <= 1'b0;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    prob_word_t exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_probs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: value=%h sat=%b", out_tdata[30:0],
                                       out_tuser[0]);
      end else begin
        exp_w = pending_probs.pop_front();
        if (out_tdata[30:0] !== exp_w.value || out_tuser[0] !== exp_w.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value exp %h got %h, sat exp %b got %b", exp_w.value,
                     out_tdata[30:0], exp_w.sat, out_tuser[0]);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    rows = '{
      '{FUNC_PDF, 32'h0000_0000, 32'h0000_0000, 31'd1, 1'b1, '{VALUE_MAX, 1'b1}},
      '{FUNC_PDF, 32'h0100_0000, 32'h0100_0000, 31'd0, 1'b1, '{VALUE_MAX, 1'b1}},
      '{FUNC_PDF, 32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 1'b1, '{31'd0, 1'b0}},
      '{FUNC_PDF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, '{31'd0, 1'b0}},
      '{FUNC_CDF, 32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 1'b1, '{31'h100_0000, 1'b0}},
      '{FUNC_CDF, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 1'b1, '{31'd0, 1'b0}},
      '{FUNC_CDF, 32'h0000_0000, 32'h0000_0000, 31'h0100_0000, 1'b0, '{31'd0, 1'b0}},
      '{FUNC_PDF, 32'h0000_0000, 32'h0000_0000, 31'h0100_0000, 1'b0, '{31'd0, 1'b0}},
      '{FUNC_CDF, 32'h0600_0000, 32'h0000_0000, 31'h0100_0000, 1'b0, '{31'd0, 1'b0}},
      '{FUNC_CDF, 32'hFA00_0000, 32'h0000_0000, 31'h0100_0000, 1'b0, '{31'd0, 1'b0}},
      '{FUNC_CDF, 32'h0600_0001, 32'h0000_0000, 31'h0100_0000, 1'b0, '{31'd0, 1'b0}},
      '{FUNC_CDF, 32'hF9FF_FFFF, 32'h0000_0000, 31'h0100_0000, 1'b0, '{31'd0, 1'b0}},
      '{FUNC_PDF, 32'h1000_0000, 32'h0000_0000, 31'h0100_0000, 1'b0, '{31'd0, 1'b0}},
      '{FUNC_PDF, 32'h0FFF_FFFF, 32'h0000_0000, 31'h0100_0000, 1'b0, '{31'd0, 1'b0}},
      '{FUNC_PDF, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, 1'b0, '{31'd0, 1'b0}},
      '{FUNC_CDF, 32'h0123_4567, 32'hFF00_0000, 31'h7FFF_FFFF, 1'b0, '{31'd0, 1'b0}},
      '{FUNC_PDF, 32'h0000_0100, 32'h0000_0000, 31'h0000_0100, 1'b0, '{31'd0, 1'b0}},
      '{FUNC_CDF, 32'hFF80_0000, 32'h0000_0000, 31'h0100_0000, 1'b0, '{31'd0, 1'b0}}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 65;
    foreach (rows[i])
      offer_word(rows[i].func, rows[i].x, rows[i].mean, rows[i].sd, rows[i].typed,
                 rows[i].want);
    repeat (160) offer_random_word();

    send_idle_pct = 65;
    recv_idle_pct = 33;
    repeat (170) offer_random_word();

    // no idling; a long receiver hold-off backs the pipeline up into the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (170) offer_random_word();
    in_tvalid <= 1'b0;

    while (pending_probs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
